// File: rtl/cip_pkg.sv
// cip_pkg: word format constants and transfer payload types for the
// complex integer power core. No dependencies.
package cip_pkg;

    // Word format: signed two's complement, Q3.44 by default
    localparam int WORD_BITS     = 48;
    localparam int FRAC_BITS_DEF = 44;
    localparam int EXP_BITS      = 16;

    // Request payload: complex base and integer exponent
    typedef struct packed {
        logic signed [WORD_BITS-1:0] base_real;
        logic signed [WORD_BITS-1:0] base_imag;
        logic        [EXP_BITS-1:0]  exponent;
    } cip_req_t;

    // Response payload: base to the exponent, saturated, sticky flag
    typedef struct packed {
        logic signed [WORD_BITS-1:0] power_real;
        logic signed [WORD_BITS-1:0] power_imag;
        logic                        overflow;
    } cip_rsp_t;

endpackage

// File: rtl/complex_integer_power_core.sv
// complex_integer_power_core: complex base raised to an unsigned integer power
// by square-and-multiply on one shared half-word multiplier. Depends on cip_pkg.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------
//  req     | in  | req_valid/req_ready  | cip_req_t: base_real, base_imag, exponent
//  rsp     | out | rsp_valid/rsp_ready  | cip_rsp_t: power_real, power_imag, overflow
//
// One item at a time. Each complex product is sixteen half-word partial
// products through the single multiplier, then a drain of the last partial and a rounding step.
// Each exponent bit above bit 0 up to its top set bit costs one squaring, and
// each set bit among them costs one further multiply into the result.
// req_ready is high only when idle; a stalled rsp holds until its transfer.
// Reset (rst_n low) returns the core to idle with no response pending.
module complex_integer_power_core #(
    parameter int FRAC_BITS = cip_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cip_pkg::cip_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output cip_pkg::cip_rsp_t rsp
);
    import cip_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int H      = (W + 1) / 2;          // low half width
    localparam int PW     = H + 1;                // signed partial operand width
    localparam int PPW    = 2 * PW;               // partial product width
    localparam int SUM_W  = 2 * W + 2;            // exact complex sum width
    localparam int RND_W  = ((SUM_W > FRAC_BITS) ? SUM_W : FRAC_BITS) + 2;
    localparam int CNT_W  = 5;                    // 16 partials plus drain flag
    localparam bit ONE_OK = (FRAC_BITS < W - 1);

    localparam logic signed [RND_W-1:0] HALF   = RND_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [W-1:0]     MAXV   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]     MINV   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]     ONE_W  = ONE_OK ? (W'(1) << FRAC_BITS) : MAXV;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_RND   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      pp_vld_reg, pp_vld_next;

    logic signed [W-1:0]       xr_reg, xr_next, xi_reg, xi_next;
    logic signed [W-1:0]       rr_reg, rr_next, ri_reg, ri_next;
    logic                      ovf_reg, ovf_next;
    logic [EXP_BITS-1:0]       e_reg, e_next;
    logic                      sq_reg, sq_next;
    logic signed [SUM_W-1:0]   acc_re_reg, acc_re_next, acc_im_reg, acc_im_next;
    logic signed [PPW-1:0]     pp_reg, pp_next;
    logic                      pp_im_reg, pp_im_next;
    logic                      pp_sub_reg, pp_sub_next;
    logic [1:0]                pp_sh_reg, pp_sh_next;

    logic [1:0]                prod_sel, part_sel;
    logic signed [W-1:0]       opnd_l, opnd_r, opnd_c, opnd_d;
    logic signed [PW-1:0]      piece_l, piece_r;
    logic signed [SUM_W-1:0]   pp_ext, pp_shift;
    logic [W:0]                rnd_re, rnd_im;

    // Round to nearest (ties up), drop fraction, saturate; returns {ovf, word}
    function automatic logic [W:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [RND_W-1:0] s;
        logic signed [RND_W-1:0] q;
        logic                    fits;
        s    = RND_W'(v) + HALF;
        q    = s >>> FRAC_BITS;
        fits = (q[RND_W-1:W-1] == '0) || (q[RND_W-1:W-1] == '1);
        if (fits)
            return {1'b0, q[W-1:0]};
        else
            return {1'b1, q[RND_W-1] ? MINV : MAXV};
    endfunction

    // Operand and half-word piece selection for the current partial product
    // real = a*c - b*d, imag = a*d + b*c; square uses c = a, d = b
    always_comb
    begin
        prod_sel = cnt_reg[3:2];
        part_sel = cnt_reg[1:0];
        opnd_c   = sq_reg ? xr_reg : rr_reg;
        opnd_d   = sq_reg ? xi_reg : ri_reg;
        opnd_l   = prod_sel[0] ? xi_reg : xr_reg;
        opnd_r   = (prod_sel[0] ^ prod_sel[1]) ? opnd_d : opnd_c;
        piece_l  = part_sel[0] ? PW'($signed(opnd_l[W-1:H]))
                               : $signed({1'b0, opnd_l[H-1:0]});
        piece_r  = part_sel[1] ? PW'($signed(opnd_r[W-1:H]))
                               : $signed({1'b0, opnd_r[H-1:0]});
    end

    // Align the registered partial product
    always_comb
    begin
        pp_ext = SUM_W'(pp_reg);
        case (pp_sh_reg)
            2'd1:    pp_shift = pp_ext <<< H;
            2'd2:    pp_shift = pp_ext <<< (2 * H);
            default: pp_shift = pp_ext;
        endcase
    end

    assign rnd_re = round_sat(acc_re_reg);
    assign rnd_im = round_sat(acc_im_reg);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        xr_next     = xr_reg;
        xi_next     = xi_reg;
        rr_next     = rr_reg;
        ri_next     = ri_reg;
        ovf_next    = ovf_reg;
        e_next      = e_reg;
        sq_next     = sq_reg;
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;

        // multiplier stage
        pp_vld_next = (state_reg == ST_MUL) && !cnt_reg[CNT_W-1];
        pp_next     = piece_l * piece_r;
        pp_im_next  = prod_sel[1];
        pp_sub_next = (prod_sel == 2'd1);
        pp_sh_next  = {1'b0, part_sel[0]} + {1'b0, part_sel[1]};

        // accumulate stage
        if (pp_vld_reg)
        begin
            if (pp_im_reg)
                acc_im_next = acc_im_reg + pp_shift;
            else if (pp_sub_reg)
                acc_re_next = acc_re_reg - pp_shift;
            else
                acc_re_next = acc_re_reg + pp_shift;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    xr_next    = req.base_real;
                    xi_next    = req.base_imag;
                    rr_next    = req.exponent[0] ? req.base_real : ONE_W;
                    ri_next    = req.exponent[0] ? req.base_imag : '0;
                    ovf_next   = !req.exponent[0] && !ONE_OK;
                    e_next     = req.exponent >> 1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (e_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    sq_next     = 1'b1;
                    cnt_next    = '0;
                    acc_re_next = '0;
                    acc_im_next = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg[CNT_W-1])
                    state_next = ST_RND;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_RND:
            begin
                ovf_next = ovf_reg | rnd_re[W] | rnd_im[W];
                if (sq_reg)
                begin
                    xr_next = rnd_re[W-1:0];
                    xi_next = rnd_im[W-1:0];
                    if (e_reg[0])
                    begin
                        sq_next     = 1'b0;
                        cnt_next    = '0;
                        acc_re_next = '0;
                        acc_im_next = '0;
                        state_next  = ST_MUL;
                    end
                    else
                    begin
                        e_next     = e_reg >> 1;
                        state_next = ST_CHECK;
                    end
                end
                else
                begin
                    rr_next    = rnd_re[W-1:0];
                    ri_next    = rnd_im[W-1:0];
                    e_next     = e_reg >> 1;
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (rsp_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            pp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pp_vld_reg <= pp_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        xr_reg     <= xr_next;
        xi_reg     <= xi_next;
        rr_reg     <= rr_next;
        ri_reg     <= ri_next;
        ovf_reg    <= ovf_next;
        e_reg      <= e_next;
        sq_reg     <= sq_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        pp_reg     <= pp_next;
        pp_im_reg  <= pp_im_next;
        pp_sub_reg <= pp_sub_next;
        pp_sh_reg  <= pp_sh_next;
    end

    // Ports
    assign req_ready       = (state_reg == ST_IDLE);
    assign rsp_valid       = (state_reg == ST_DONE);
    assign rsp.power_real  = rr_reg;
    assign rsp.power_imag  = ri_reg;
    assign rsp.overflow    = ovf_reg;

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request and response sides active together");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == ST_CHECK)
        else $error("accepted request did not start the sequence");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL && !cnt_reg[CNT_W-1] |=>
            state_reg == ST_MUL && cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("partial product counter skipped");

    a_drain_round: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RND |-> !pp_vld_reg)
        else $error("rounding with a partial product still in flight");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK && e_reg == '0 |=> rsp_valid)
        else $error("exhausted exponent did not present a response");

endmodule

// File: tb/sv/cip_power_checker.sv
// cip_power_checker: watches the request and response channels of the complex
// integer power core, predicts each power and compares it field by field.
// Depends on cip_pkg.
module cip_power_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  cip_pkg::cip_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  cip_pkg::cip_rsp_t rsp,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cip_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [127:0]         acc_t;

    localparam acc_t WORD_MAX = (acc_t'(1) <<< (WORD_BITS - 1)) - acc_t'(1);
    localparam acc_t WORD_MIN = -(acc_t'(1) <<< (WORD_BITS - 1));

    cip_rsp_t expected_powers[$];
    int       errors = 0;

    // Round to nearest (ties up), drop the fraction, clamp to the word
    function automatic word_t round_to_word(input acc_t sum, output logic clipped);
        acc_t scaled;
        scaled  = (sum + (acc_t'(1) <<< (FRAC - 1))) >>> FRAC;
        clipped = 1'b0;
        if (scaled > WORD_MAX) begin
            clipped = 1'b1;
            scaled  = WORD_MAX;
        end
        else if (scaled < WORD_MIN) begin
            clipped = 1'b1;
            scaled  = WORD_MIN;
        end
        return scaled[WORD_BITS-1:0];
    endfunction

    // (ar + ai i)(br + bi i), each part summed exactly then rounded once
    function automatic void complex_product(input word_t ar, input word_t ai,
                                            input word_t br, input word_t bi,
                                            output word_t pr, output word_t pi,
                                            output logic clipped);
        logic clip_re;
        logic clip_im;
        pr = round_to_word(acc_t'(ar) * acc_t'(br) - acc_t'(ai) * acc_t'(bi), clip_re);
        pi = round_to_word(acc_t'(ar) * acc_t'(bi) + acc_t'(ai) * acc_t'(br), clip_im);
        clipped = clip_re | clip_im;
    endfunction

    // Binary square-and-multiply, least significant exponent bit first
    function automatic cip_rsp_t predict_power(input cip_req_t item);
        word_t                xr;
        word_t                xi;
        word_t                rr;
        word_t                ri;
        word_t                nr;
        word_t                ni;
        logic [EXP_BITS-1:0]  bits;
        logic                 sticky;
        logic                 clipped;
        acc_t                 unit;
        cip_rsp_t             res;
        xr     = item.base_real;
        xi     = item.base_imag;
        bits   = item.exponent;
        sticky = 1'b0;
        if (bits[0]) begin
            rr = xr;
            ri = xi;
        end
        else begin
            // one clamps when the format has no integer bit for it
            unit = acc_t'(1) <<< FRAC;
            if (unit > WORD_MAX) begin
                unit   = WORD_MAX;
                sticky = 1'b1;
            end
            rr = unit[WORD_BITS-1:0];
            ri = '0;
        end
        bits = bits >> 1;
        while (bits != 0) begin
            complex_product(xr, xi, xr, xi, nr, ni, clipped);
            sticky = sticky | clipped;
            xr     = nr;
            xi     = ni;
            if (bits[0]) begin
                complex_product(xr, xi, rr, ri, nr, ni, clipped);
                sticky = sticky | clipped;
                rr     = nr;
                ri     = ni;
            end
            bits = bits >> 1;
        end
        res.power_real = rr;
        res.power_imag = ri;
        res.overflow   = sticky;
        return res;
    endfunction

    task automatic check_field(input string label, input logic [WORD_BITS-1:0] want,
                               input logic [WORD_BITS-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, label, want, got);
        end
    endtask

    // Response first: a request taken at this edge cannot be answered at it
    always @(posedge clk) begin : monitor
        cip_rsp_t want;
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                if (expected_powers.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response transfer, expected none actual %h",
                             $time, rsp);
                end
                else begin
                    want = expected_powers.pop_front();
                    check_field("power_real", want.power_real, rsp.power_real);
                    check_field("power_imag", want.power_imag, rsp.power_imag);
                    check_field("overflow", WORD_BITS'(want.overflow), WORD_BITS'(rsp.overflow));
                end
            end
            if (req_valid && req_ready)
                expected_powers.push_back(predict_power(req));
            pending    <= expected_powers.size();
            fail_count <= errors;
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// tb_top: stimulus and verdict for complex_integer_power_core.
// Depends on cip_pkg, complex_integer_power_core and cip_power_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cip_pkg::*;

    localparam int RANDOM_ITEMS  = 1530;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 600;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t Q_ONE  = word_t'(64'd1 << FRAC_BITS_DEF);
    localparam word_t W_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t W_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t W_TIE  = word_t'(64'd1 << (FRAC_BITS_DEF / 2 - 1));

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    cip_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    cip_rsp_t rsp;
    int       fail_count;
    int       pending;
    bit       quiet_tx = 1'b0;
    bit       quiet_rx = 1'b0;

    complex_integer_power_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    cip_power_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, none while quiet
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 100);
    endfunction

    // Signed value of magnitude below 2^bits
    function automatic word_t span_value(input int bits);
        logic [63:0] raw;
        longint      v;
        raw = {$urandom, $urandom};
        v   = longint'(raw & ((64'd1 << bits) - 64'd1));
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v[WORD_BITS-1:0];
    endfunction

    // Point near the unit circle, with noise in the low bits
    function automatic void unit_point(output word_t re, output word_t im);
        real    c;
        real    s;
        longint vr;
        longint vi;
        c = $urandom_range(0, 2000000) / 1000000.0 - 1.0;
        s = $sqrt(1.0 - c * c);
        if ($urandom_range(0, 1) == 1)
            s = -s;
        vr = longint'(c * 17592186044416.0) + longint'($urandom_range(0, 2047)) - 1024;
        vi = longint'(s * 17592186044416.0) + longint'($urandom_range(0, 2047)) - 1024;
        re = vr[WORD_BITS-1:0];
        im = vi[WORD_BITS-1:0];
    endfunction

    function automatic cip_req_t random_item();
        cip_req_t    item;
        int          r;
        logic [63:0] raw;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            unit_point(item.base_real, item.base_imag);
        end
        else if (r < 55) begin
            item.base_real = span_value(FRAC_BITS_DEF + 1);
            item.base_imag = span_value(FRAC_BITS_DEF + 1);
        end
        else if (r < 65) begin
            item.base_real = span_value(FRAC_BITS_DEF + 2);
            item.base_imag = span_value(FRAC_BITS_DEF + 2);
        end
        else if (r < 85) begin
            raw            = {$urandom, $urandom};
            item.base_real = raw[WORD_BITS-1:0];
            raw            = {$urandom, $urandom};
            item.base_imag = raw[WORD_BITS-1:0];
        end
        else begin
            item.base_real = span_value(24);
            item.base_imag = span_value(24);
        end
        // long exponents take the longest to compute, so keep most of them short
        r = $urandom_range(0, 99);
        if (r < 50)
            item.exponent = EXP_BITS'($urandom_range(0, 31));
        else if (r < 75)
            item.exponent = EXP_BITS'($urandom_range(0, 1023));
        else
            item.exponent = EXP_BITS'($urandom_range(0, (1 << EXP_BITS) - 1));
        return item;
    endfunction

    // Offer one request and hold it until the transfer
    task automatic push_item(input cip_req_t item);
        int gap;
        gap = pick_gap(quiet_tx);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic push_base(input word_t re, input word_t im,
                             input logic [EXP_BITS-1:0] power);
        cip_req_t item;
        item.base_real = re;
        item.base_imag = im;
        item.exponent  = power;
        push_item(item);
    endtask

    task automatic push_unit(input logic [EXP_BITS-1:0] power);
        word_t re;
        word_t im;
        unit_point(re, im);
        push_base(re, im, power);
    endtask

    // Hold off the sender until every result has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Response side: ready in bursts broken by random stalls
    initial begin : rsp_side
        int hold;
        int stall;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 29) == 0)
                quiet_rx = !quiet_rx;
            rsp_ready <= 1'b1;
            hold = $urandom_range(1, 40);
            repeat (hold) @(posedge clk);
            stall = pick_gap(quiet_rx);
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int n;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero exponent gives one whatever the base; exponent one passes it through
        push_base(W_MAX, W_MIN, 16'h0000);
        push_base(W_MIN, W_MAX, 16'h0000);
        push_base(W_MAX, W_MIN, 16'h0001);
        push_base(W_MIN, W_MAX, 16'h0001);
        // fixed points and rotations by i
        push_base('0, '0, 16'hFFFF);
        push_base(Q_ONE, '0, 16'hFFFF);
        push_base(-Q_ONE, '0, 16'hFFFF);
        push_base('0, Q_ONE, 16'h0002);
        push_base('0, Q_ONE, 16'h0003);
        push_base('0, -Q_ONE, 16'h8000);
        // saturation, then saturated values carried onward
        push_base(W_MAX, W_MAX, 16'h0002);
        push_base(W_MIN, '0, 16'h0002);
        push_base(W_MIN, '0, 16'h0003);
        push_base(W_MIN, W_MIN, 16'hFFFF);
        // exact half in the rounding, positive and negative
        push_base(W_TIE, W_TIE, 16'h0002);
        push_base(W_TIE, -W_TIE, 16'h0002);
        // slow growth, and decay to zero
        push_base(Q_ONE + 1, 1, 16'hFFFF);
        push_base(Q_ONE >>> 1, Q_ONE >>> 1, 16'h00FF);
        push_unit(16'hAAAA);
        push_unit(16'h5555);
        push_unit(16'h8000);
        wait_drained();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 59) == 0)
                quiet_tx = !quiet_tx;
            if ($urandom_range(0, 199) == 0)
                wait_drained();
            push_item(random_item());
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/cip_pkg.sv
rtl/complex_integer_power_core.sv
tb/sv/cip_power_checker.sv
tb/sv/tb_top.sv
